// ===== design/ftr_pkg.sv =====
// Shared types and constants of the four-connected line tracer.
package ftr_pkg;

    localparam int SCR_W      = 13;
    localparam int TRAIL_W    = 16;
    localparam int DEPTH_W    = 5;
    localparam int LIVE_W     = TRAIL_W + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCR_W-1:0]   SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCR_W-1:0]   SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [TRAIL_W-1:0] TRAIL_LENGTH_RST  = 16'd1000;
    localparam logic [DEPTH_W-1:0] DEDUP_DEPTH_RST   = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_LENGTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_DEPTH   = 8'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRACE,
        ST_FLUSH
    } t_state;

endpackage

// ===== design/four_connected_line_tracer_top.sv =====
// Top level of the four-connected line tracer: sample handling, line stepper and output stage.
// Each pen-down sample on screen is joined to the last kept pixel by a 4-connected Bresenham
// line; traced pixels that repeat one of the last dedup_depth kept pixels are dropped. The
// stepper makes one x or y move per cycle while the output side is not stalled. A pen-up or
// off-screen sample is done in the idle state; the first point of a trail or an over-long
// segment goes through the flush state, and a traced segment of at most MAX_SPAN moves goes
// through the trace and flush states. One sample is worked at a time; s_axis_tready is high
// while idle. An over-long segment gives a single result with tuser set. The recent pixels
// sit in a chain of MAX_CHECK cells that shifts on every kept pixel. Configuration is taken
// at any time on the cfg channel but must only change while no sample is in flight.
module four_connected_line_tracer_top #(
    parameter int COORD_BITS = 12,
    parameter int MAX_CHECK  = 16,
    parameter int MAX_SPAN   = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // request in: tdata = sample_x, sample_y; tuser = pen_down
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                    s_axis_tuser,
    // result out: tdata = pixel_x, pixel_y; tlast = last_of_run; tuser = span_error
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                    m_axis_tlast,
    output logic                                    m_axis_tuser,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ftr_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [ftr_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    import ftr_pkg::*;

    localparam int DATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int CNT_W  = $clog2(MAX_CHECK+1);
    localparam int SPAN_W = $clog2(MAX_SPAN+1);
    localparam int ERR_W  = SPAN_W + 2;

    // configuration
    logic [SCR_W-1:0]   r_scr_w;
    logic [SCR_W-1:0]   r_scr_h;
    logic [TRAIL_W-1:0] r_trail;
    logic [DEPTH_W-1:0] r_dedup;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [TRAIL_W-1:0] r_kept, n_kept;
    logic [LIVE_W-1:0]  r_live, n_live;

    // stepper
    logic [COORD_BITS-1:0]   r_x, n_x, r_y, n_y, r_tx, n_tx, r_ty, n_ty;
    logic [SPAN_W-1:0]       r_dx, n_dx, r_dy, n_dy, r_steps, n_steps;
    logic                    r_sx, n_sx, r_sy, n_sy;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic                    r_phase_y, n_phase_y, r_my, n_my;

    // pending pixel (held back until the next one shows whether it is last)
    logic                  r_pend_valid, n_pend_valid;
    logic [COORD_BITS-1:0] r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic                  r_pend_span, n_pend_span;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic                  r_out_last, n_out_last, r_out_span, n_out_span;

    logic [COORD_BITS-1:0] in_x, in_y, head_x, head_y, cand_x, cand_y, mv_x, mv_y;
    logic                  in_pen, in_range, in_acc, dup, push;
    logic [COORD_BITS-1:0] full_dx, full_dy;
    logic [COORD_BITS:0]   full_sum;
    logic                  over_span;
    logic                  start_first, start_span, start_trace;
    logic                  y_pend, loop_live, trace_end, do_x, mx, my;
    logic signed [ERR_W:0] e2;
    logic                  out_free, can_emit, flush_done;
    logic [CNT_W-1:0]      cmp_n;
    logic [31:0]           eff_depth;

    assign in_x   = s_axis_tdata[COORD_BITS-1:0];
    assign in_y   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_pen = s_axis_tuser;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign in_range = (LIVE_W'(in_x) < LIVE_W'(r_scr_w)) && (LIVE_W'(in_y) < LIVE_W'(r_scr_h));

    assign full_dx   = (in_x > head_x) ? in_x - head_x : head_x - in_x;
    assign full_dy   = (in_y > head_y) ? in_y - head_y : head_y - in_y;
    assign full_sum  = {1'b0, full_dx} + {1'b0, full_dy};
    assign over_span = 32'(full_sum) > 32'(MAX_SPAN);

    assign start_first = in_acc && in_pen && in_range && (r_kept == '0);
    assign start_span  = in_acc && in_pen && in_range && (r_kept != '0) && over_span;
    assign start_trace = in_acc && in_pen && in_range && (r_kept != '0) && !over_span;

    // one move per cycle unless the output stalls; a split diagonal makes its x move, then its y move
    assign y_pend    = r_phase_y && r_my && (r_steps != '0);
    assign loop_live = (r_steps != '0) && ((r_x != r_tx) || (r_y != r_ty));
    assign trace_end = !y_pend && !loop_live;
    assign e2        = {r_err, 1'b0};
    assign mx        = e2 > -$signed({2'b00, r_dy});
    assign my        = e2 < $signed({2'b00, r_dx});
    assign do_x      = !y_pend && mx;

    always_comb begin
        mv_x = r_x;
        mv_y = r_y;
        if (do_x) begin
            mv_x = r_sx ? r_x + 1'b1 : r_x - 1'b1;
        end else begin
            mv_y = r_sy ? r_y + 1'b1 : r_y - 1'b1;
        end
    end

    assign cand_x = (r_state == ST_IDLE) ? in_x : mv_x;
    assign cand_y = (r_state == ST_IDLE) ? in_y : mv_y;

    assign out_free   = !r_out_valid || m_axis_tready;
    assign can_emit   = !r_pend_valid || out_free;
    assign flush_done = !r_pend_valid || out_free;

    assign eff_depth = (32'(r_dedup) > 32'(MAX_CHECK)) ? 32'(MAX_CHECK) : 32'(r_dedup);
    assign cmp_n     = (LIVE_W'(eff_depth) > r_live) ? r_live[CNT_W-1:0]
                                                     : eff_depth[CNT_W-1:0];

    assign push = start_first ||
                  ((r_state == ST_TRACE) && !trace_end && can_emit && !dup);

    ftr_chain #(
        .COORD_BITS (COORD_BITS),
        .MAX_CHECK  (MAX_CHECK),
        .CNT_W      (CNT_W)
    ) u_chain (
        .i_clk    (i_clk),
        .i_push   (push),
        .i_cand_x (cand_x),
        .i_cand_y (cand_y),
        .i_cmp_n  (cmp_n),
        .o_dup    (dup),
        .o_head_x (head_x),
        .o_head_y (head_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start_first || start_span) n_state = ST_FLUSH;
                else if (start_trace)          n_state = ST_TRACE;
            end
            ST_TRACE: begin
                if (trace_end) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (flush_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_kept       = r_kept;
        n_live       = r_live;
        n_x          = r_x;
        n_y          = r_y;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_steps      = r_steps;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_err        = r_err;
        n_phase_y    = r_phase_y;
        n_my         = r_my;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_pend_span  = r_pend_span;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_last   = r_out_last;
        n_out_span   = r_out_span;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && !in_pen) begin
                    n_kept = '0;
                end
                if (start_first) begin
                    n_live       = LIVE_W'(1);
                    n_pend_valid = 1'b1;
                    n_pend_x     = in_x;
                    n_pend_y     = in_y;
                    n_pend_span  = 1'b0;
                end
                if (start_span) begin
                    n_live       = LIVE_W'(r_kept);
                    n_pend_valid = 1'b1;
                    n_pend_x     = '0;
                    n_pend_y     = '0;
                    n_pend_span  = 1'b1;
                end
                if (start_trace) begin
                    n_live    = LIVE_W'(r_kept);
                    n_x       = head_x;
                    n_y       = head_y;
                    n_tx      = in_x;
                    n_ty      = in_y;
                    n_dx      = full_dx[SPAN_W-1:0];
                    n_dy      = full_dy[SPAN_W-1:0];
                    n_steps   = full_sum[SPAN_W-1:0];
                    n_sx      = head_x < in_x;
                    n_sy      = head_y < in_y;
                    n_err     = $signed(ERR_W'(full_dx[SPAN_W-1:0]))
                              - $signed(ERR_W'(full_dy[SPAN_W-1:0]));
                    n_phase_y = 1'b0;
                    n_my      = 1'b0;
                end
            end
            ST_TRACE: begin
                if (!trace_end && can_emit) begin
                    n_x     = mv_x;
                    n_y     = mv_y;
                    n_steps = r_steps - 1'b1;
                    if (do_x) begin
                        n_err     = r_err - $signed(ERR_W'(r_dy));
                        n_phase_y = 1'b1;
                        n_my      = my;
                    end else begin
                        n_err     = r_err + $signed(ERR_W'(r_dx));
                        n_phase_y = 1'b0;
                    end
                    if (!dup) begin
                        n_live       = r_live + 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_x     = mv_x;
                        n_pend_y     = mv_y;
                        n_pend_span  = 1'b0;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_x     = r_pend_x;
                            n_out_y     = r_pend_y;
                            n_out_last  = 1'b0;
                            n_out_span  = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (flush_done) begin
                    if (r_pend_valid) begin
                        n_pend_valid = 1'b0;
                        n_out_valid  = 1'b1;
                        n_out_x      = r_pend_x;
                        n_out_y      = r_pend_y;
                        n_out_last   = 1'b1;
                        n_out_span   = r_pend_span;
                    end
                    // cap the trail once the sample is done; an over-long segment leaves it
                    if (!(r_pend_valid && r_pend_span)) begin
                        n_kept = (r_live < LIVE_W'(r_trail)) ? r_live[TRAIL_W-1:0] : r_trail;
                    end
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_kept       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_kept       <= n_kept;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_live      <= n_live;
        r_x         <= n_x;
        r_y         <= n_y;
        r_tx        <= n_tx;
        r_ty        <= n_ty;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_steps     <= n_steps;
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_err       <= n_err;
        r_phase_y   <= n_phase_y;
        r_my        <= n_my;
        r_pend_x    <= n_pend_x;
        r_pend_y    <= n_pend_y;
        r_pend_span <= n_pend_span;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_last  <= n_out_last;
        r_out_span  <= n_out_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCREEN_WIDTH_RST;
            r_scr_h <= SCREEN_HEIGHT_RST;
            r_trail <= TRAIL_LENGTH_RST;
            r_dedup <= DEDUP_DEPTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data[SCR_W-1:0];
                CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data[SCR_W-1:0];
                CFG_TRAIL_LENGTH:  r_trail <= i_cfg_data[TRAIL_W-1:0];
                CFG_DEDUP_DEPTH:   r_dedup <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'({r_out_y, r_out_x});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_span;

endmodule

// ===== design/ftr_cell.sv =====
// One cell of the recent-pixel chain: holds a pixel and compares it with the candidate.
module ftr_cell #(
    parameter int COORD_BITS = 12,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  logic                  i_push,
    input  logic [COORD_BITS-1:0] i_prev_x,
    input  logic [COORD_BITS-1:0] i_prev_y,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  logic [CNT_W-1:0]      i_cmp_n,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic                  o_match
);

    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;

    // contents are only read once written, so no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_x <= i_prev_x;
            r_y <= i_prev_y;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_match = (CNT_W'(IDX) < i_cmp_n) && (r_x == i_cand_x) && (r_y == i_cand_y);

endmodule

// ===== design/ftr_chain.sv =====
// Row of recent-pixel cells, newest first, with the duplicate flag gathered over the row.
module ftr_chain #(
    parameter int COORD_BITS = 12,
    parameter int MAX_CHECK  = 16,
    parameter int CNT_W      = 5
) (
    input  logic                  i_clk,
    input  logic                  i_push,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  logic [CNT_W-1:0]      i_cmp_n,
    output logic                  o_dup,
    output logic [COORD_BITS-1:0] o_head_x,
    output logic [COORD_BITS-1:0] o_head_y
);

    logic [COORD_BITS-1:0] w_x [0:MAX_CHECK];
    logic [COORD_BITS-1:0] w_y [0:MAX_CHECK];
    logic [MAX_CHECK-1:0]  w_match;

    assign w_x[0] = i_cand_x;
    assign w_y[0] = i_cand_y;

    for (genvar g = 0; g < MAX_CHECK; g++) begin : g_cell
        ftr_cell #(
            .COORD_BITS (COORD_BITS),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_push   (i_push),
            .i_prev_x (w_x[g]),
            .i_prev_y (w_y[g]),
            .i_cand_x (i_cand_x),
            .i_cand_y (i_cand_y),
            .i_cmp_n  (i_cmp_n),
            .o_x      (w_x[g+1]),
            .o_y      (w_y[g+1]),
            .o_match  (w_match[g])
        );
    end

    assign o_dup    = |w_match;
    assign o_head_x = w_x[1];
    assign o_head_y = w_y[1];

endmodule

// ===== tb/four_connected_line_tracer_top_tb.sv =====
// Self-checking testbench for the four-connected line tracer: directed, random, output hold.
`timescale 1ns / 1ps

module four_connected_line_tracer_top_tb;
    import ftr_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int MAX_CHECK      = 16;
    localparam int MAX_SPAN       = 64;
    localparam int DATA_W         = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES  = MAX_SPAN + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int EXP_DEPTH      = 256;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic        last;
        logic        span;
    } t_pixel;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    four_connected_line_tracer_top #(
        .COORD_BITS (COORD_BITS),
        .MAX_CHECK  (MAX_CHECK),
        .MAX_SPAN   (MAX_SPAN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [11:0] sample_x, [23:12] sample_y
        .s_axis_tuser  (s_axis_tuser),   // pen_down
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [11:0] pixel_x, [23:12] pixel_y
        .m_axis_tlast  (m_axis_tlast),   // last_of_run
        .m_axis_tuser  (m_axis_tuser),   // span_error
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Tracer copy: settings, recent-pixel ring and trail count
    logic [SCR_W-1:0]   cfg_width  = SCREEN_WIDTH_RST;
    logic [SCR_W-1:0]   cfg_height = SCREEN_HEIGHT_RST;
    logic [TRAIL_W-1:0] cfg_trail  = TRAIL_LENGTH_RST;
    logic [DEPTH_W-1:0] cfg_dedup  = DEDUP_DEPTH_RST;
    logic [11:0]        kept_x [MAX_CHECK];
    logic [11:0]        kept_y [MAX_CHECK];
    int                 kept_head   = 0;
    int                 trail_count = 0;
    int                 work_count  = 0;

    // expected results, a ring with running write and read counts
    t_pixel exp_pixels [EXP_DEPTH];
    int     exp_wr = 0;
    int     exp_rd = 0;
    t_pixel head_px;

    int error_count    = 0;
    int samples_taken  = 0;
    int pixels_checked = 0;
    int span_flags     = 0;
    int reg_writes     = 0;
    int quiet_cycles   = 0;
    int src_idle_pct   = 0;
    int dst_idle_pct   = 0;
    int hold_cycles    = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void expect_pixel(t_pixel p);
        exp_pixels[exp_wr % EXP_DEPTH] = p;
        exp_wr++;
    endfunction

    function automatic int exp_pending();
        return exp_wr - exp_rd;
    endfunction

    // k-th most recent kept pixel, k from 1
    function automatic int recent_idx(int k);
        return (kept_head + MAX_CHECK - (k % MAX_CHECK)) % MAX_CHECK;
    endfunction

    function automatic bit seen_recently(int x, int y);
        int  n;
        bit  hit;
        n   = int'(cfg_dedup);
        hit = 1'b0;
        if (n > MAX_CHECK) n = MAX_CHECK;
        if (n > work_count) n = work_count;
        for (int k = 1; k <= n; k++) begin
            if (kept_x[recent_idx(k)] == x && kept_y[recent_idx(k)] == y) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void keep_pixel(int x, int y);
        t_pixel p;
        kept_x[kept_head] = x[11:0];
        kept_y[kept_head] = y[11:0];
        kept_head = (kept_head + 1) % MAX_CHECK;
        work_count++;
        p.x    = x[11:0];
        p.y    = y[11:0];
        p.last = 1'b0;
        p.span = 1'b0;
        expect_pixel(p);
    endfunction

    // Works out the pixels one accepted request adds to the trail
    function automatic void trace_sample(logic [11:0] sx, logic [11:0] sy, logic pen);
        int     x, y, tx, ty, dx, dy, stx, sty, err, e2, steps, first_new;
        bit     mx, my;
        t_pixel p;
        if (!pen) begin
            trail_count = 0;
            return;
        end
        if (sx >= cfg_width || sy >= cfg_height) return;
        work_count = trail_count;
        first_new  = exp_wr;
        if (work_count == 0) begin
            keep_pixel(int'(sx), int'(sy));
        end else begin
            x   = int'(kept_x[recent_idx(1)]);
            y   = int'(kept_y[recent_idx(1)]);
            tx  = int'(sx);
            ty  = int'(sy);
            dx  = (tx > x) ? tx - x : x - tx;
            dy  = (ty > y) ? ty - y : y - ty;
            stx = (x < tx) ? 1 : -1;
            sty = (y < ty) ? 1 : -1;
            err = dx - dy;
            if (dx + dy > MAX_SPAN) begin
                p.x    = '0;
                p.y    = '0;
                p.last = 1'b1;
                p.span = 1'b1;
                expect_pixel(p);
                return;
            end
            steps = dx + dy;
            // a diagonal step becomes an x move then a y move
            while (steps > 0 && (x != tx || y != ty)) begin
                e2 = 2 * err;
                mx = e2 > -dy;
                my = e2 < dx;
                if (mx) begin
                    err -= dy;
                    x   += stx;
                    steps--;
                    if (!seen_recently(x, y)) keep_pixel(x, y);
                end
                if (my && steps > 0) begin
                    err += dx;
                    y   += sty;
                    steps--;
                    if (!seen_recently(x, y)) keep_pixel(x, y);
                end
            end
        end
        trail_count = (work_count < int'(cfg_trail)) ? work_count : int'(cfg_trail);
        if (exp_wr > first_new)
            exp_pixels[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    endfunction

    // Input side: predict on every accepted request and every register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                trace_sample(s_axis_tdata[11:0], s_axis_tdata[23:12], s_axis_tuser);
                samples_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  cfg_width  = i_cfg_data[SCR_W-1:0];
                    CFG_SCREEN_HEIGHT: cfg_height = i_cfg_data[SCR_W-1:0];
                    CFG_TRAIL_LENGTH:  cfg_trail  = i_cfg_data[TRAIL_W-1:0];
                    CFG_DEDUP_DEPTH:   cfg_dedup  = i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Output side: compare each result with the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_pending() == 0) begin
                $error("unexpected result: tdata %h tlast %b tuser %b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count++;
            end else begin
                head_px = exp_pixels[exp_rd % EXP_DEPTH];
                exp_rd++;
                pixels_checked++;
                if (m_axis_tuser) span_flags++;
                if (m_axis_tdata[11:0] !== head_px.x) begin
                    $error("pixel_x: expected %0d, got %0d", head_px.x, m_axis_tdata[11:0]);
                    error_count++;
                end
                if (m_axis_tdata[23:12] !== head_px.y) begin
                    $error("pixel_y: expected %0d, got %0d", head_px.y, m_axis_tdata[23:12]);
                    error_count++;
                end
                if (m_axis_tlast !== head_px.last) begin
                    $error("last_of_run: expected %0d, got %0d", head_px.last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== head_px.span) begin
                    $error("span_error: expected %0d, got %0d", head_px.span, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold while hold_cycles runs down
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("four_connected_line_tracer_top_tb: done, errors");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    // tvalid is left high so back-to-back requests need no second assignment per step.
    task automatic offer_sample(input logic [11:0] sx, input logic [11:0] sy, input logic pen);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sy, sx};
        s_axis_tuser  <= pen;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Drops tvalid, waits for every expected pixel, then lets a silent trace finish
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (exp_pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input int w, input int h, input int trail, input int depth);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idx[0] = CFG_SCREEN_WIDTH;   vals[0] = CFG_DATA_W'(w);
        idx[1] = CFG_SCREEN_HEIGHT;  vals[1] = CFG_DATA_W'(h);
        idx[2] = CFG_TRAIL_LENGTH;   vals[2] = CFG_DATA_W'(trail);
        idx[3] = CFG_DEDUP_DEPTH;    vals[3] = CFG_DATA_W'(depth);
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int fold_into(int c, int d, int lim);
        int t;
        t = c + d;
        if (t < 0 || t >= lim) t = c - d;
        if (t < 0) t = 0;
        if (t >= lim) t = lim - 1;
        return t;
    endfunction

    // Reset settings: first point, same point, lines, span limit, off screen
    task automatic test_trail_start_and_lines();
        src_idle_pct = 20;
        dst_idle_pct = 30;
        offer_sample(12'd4095, 12'd4095, 1'b0);
        offer_sample(12'd0, 12'd0, 1'b1);
        offer_sample(12'd0, 12'd0, 1'b1);
        offer_sample(12'd5, 12'd3, 1'b1);
        offer_sample(12'd1023, 12'd767, 1'b1);
        offer_sample(12'd1024, 12'd5, 1'b1);
        offer_sample(12'd5, 12'd768, 1'b1);
        offer_sample(12'd69, 12'd3, 1'b1);    // longest allowed segment
        offer_sample(12'd5, 12'd3, 1'b1);     // retrace, recent pixels dropped
        settle_block();
    endtask

    task automatic test_screen_limits();
        load_settings(4096, 4096, 1000, 16);
        offer_sample(12'd0, 12'd0, 1'b0);
        offer_sample(12'd4095, 12'd4095, 1'b1);
        offer_sample(12'd4095, 12'd0, 1'b1);
        offer_sample(12'd4063, 12'd4063, 1'b1);
        settle_block();
        load_settings(1, 1, 1000, 16);
        offer_sample(12'd0, 12'd0, 1'b1);
        offer_sample(12'd1, 12'd0, 1'b1);
        settle_block();
        load_settings(0, 0, 1000, 16);        // zero-size screen takes nothing
        offer_sample(12'd0, 12'd0, 1'b1);
        settle_block();
    endtask

    task automatic test_dedup_and_trail_length();
        load_settings(1024, 768, 0, 0);
        offer_sample(12'd10, 12'd10, 1'b0);
        offer_sample(12'd10, 12'd10, 1'b1);
        offer_sample(12'd12, 12'd12, 1'b1);   // empty trail, so a fresh start
        settle_block();
        load_settings(1024, 768, 65535, 31);  // depth past the ring acts as full ring
        offer_sample(12'd14, 12'd12, 1'b1);
        offer_sample(12'd20, 12'd12, 1'b1);
        offer_sample(12'd14, 12'd12, 1'b1);   // every pixel a repeat
        settle_block();
        load_settings(1024, 768, 1, 0);
        offer_sample(12'd16, 12'd12, 1'b1);
        offer_sample(12'd14, 12'd12, 1'b1);
        settle_block();
    endtask

    // Mostly connected strokes, with pen ups, off-screen points, repeats and long jumps
    task automatic test_random_strokes(input int n_items, input int src_pct, input int rx_pct);
        int   w, h, cx, cy, ddx, ddy, tx, ty, roll, room;
        logic pen;
        src_idle_pct = src_pct;
        dst_idle_pct = rx_pct;
        w = (int'(cfg_width) > 4096) ? 4096 : int'(cfg_width);
        h = (int'(cfg_height) > 4096) ? 4096 : int'(cfg_height);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            pen  = 1'b1;
            tx   = $urandom_range(4095, 0);
            ty   = $urandom_range(4095, 0);
            if (roll < 5) begin
                pen = 1'b0;
            end else if (roll < 10) begin
                if (w < 4096) tx = $urandom_range(4095, w);
                else if (h < 4096) ty = $urandom_range(4095, h);
            end else if (trail_count == 0 || roll < 14) begin
                tx = $urandom_range(w - 1, 0);
                ty = $urandom_range(h - 1, 0);
            end else begin
                cx = int'(kept_x[recent_idx(1)]);
                cy = int'(kept_y[recent_idx(1)]);
                if (roll < 19) begin
                    ddx = 0;
                    ddy = 0;
                end else if (roll < 26) begin
                    ddx = 33 + $urandom_range(30);
                    ddy = 33 + $urandom_range(30);
                    if ($urandom_range(1)) ddx = -ddx;
                    if ($urandom_range(1)) ddy = -ddy;
                end else begin
                    ddx  = $urandom_range(64);
                    ddx -= 32;
                    room = MAX_SPAN - ((ddx < 0) ? -ddx : ddx);
                    ddy  = $urandom_range(2 * room);
                    ddy -= room;
                end
                tx = fold_into(cx, ddx, w);
                ty = fold_into(cy, ddy, h);
            end
            offer_sample(tx[11:0], ty[11:0], pen);
        end
        settle_block();
    endtask

    // Output held off while requests keep coming, so the input side must stall
    task automatic test_output_hold();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_cycles  = 300;
        offer_sample(12'd1000, 12'd1000, 1'b0);
        for (int i = 0; i < 12; i++)
            offer_sample(12'(1000 + (i % 2) * 32), 12'(1000 + i * 20), 1'b1);
        settle_block();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_trail_start_and_lines();
        test_screen_limits();
        test_dedup_and_trail_length();
        load_settings(4096, 4096, 1000, 8);
        test_random_strokes(85, 6, 86);
        load_settings(640, 480, 5, 16);
        test_random_strokes(85, 86, 6);
        load_settings(8191, 8191, 65535, 3);
        test_random_strokes(85, 0, 0);
        test_output_hold();

        $display("four_connected_line_tracer_top_tb: %0d samples, %0d results checked,",
                 samples_taken, pixels_checked);
        $display("  %0d span flags, %0d register writes; screens 0..8191, trail 0..65535, %s",
                 span_flags, reg_writes, "dedup 0..31, three idle mixes, long output hold");
        if (error_count == 0)
            $display("four_connected_line_tracer_top_tb: done, clean");
        else
            $display("four_connected_line_tracer_top_tb: done, errors");
        $finish;
    end

endmodule
